@@ hdl/kwp2000_frame_receiver_unit_macros.svh @@
// ----------------------------------------------------------------------------
// KWP2000 frame receiver assertion macros
// Clocked property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef KWP2000_FRAME_RECEIVER_UNIT_MACROS_SVH
`define KWP2000_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held low.
`define KWP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kwp2000 frame receiver: property violated");

// Next-cycle implication, disabled while reset is held low.
`define KWP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kwp2000 frame receiver: property violated");

`endif

@@ hdl/kwp_pkg.sv @@
// ----------------------------------------------------------------------------
// KWP2000 frame receiver package
// Shared types, status codes and stream field layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kwp_pkg;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_TUSER_W = 3;

  // Output tdata field positions
  localparam int unsigned PIDX_LSB = 0;
  localparam int unsigned PBYTE_LSB = 8;
  localparam int unsigned HLEN_LSB = 16;
  localparam int unsigned DLEN_LSB = 19;
  localparam int unsigned DLEN_MSB = 26;

  // Format byte fields
  localparam logic [1:0] FMT_MODE_BAD = 2'b01;

  typedef enum logic [1:0] {
    STS_NEED    = 2'd0,
    STS_DONE_OK = 2'd1,
    STS_ERROR   = 2'd2,
    STS_ABORTED = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0] hdr_cnt;
    logic [2:0] hdr_len;
    logic [7:0] data_len;
    logic [8:0] data_cnt;
    logic [7:0] sum;
  } frame_state_t;

  typedef struct packed {
    status_t    status;
    logic       payload_valid;
    logic [7:0] payload_index;
    logic [7:0] payload_byte;
    logic [2:0] hdr_len;
    logic [7:0] data_len;
  } frame_result_t;

endpackage

`default_nettype wire

@@ hdl/kwp_frame_step.sv @@
// ----------------------------------------------------------------------------
// KWP2000 frame step logic
// Next frame state and result for one received byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kwp_frame_step (
  input  kwp_pkg::frame_state_t  st,
  input  logic [7:0]             rx_byte,
  input  logic                   abort,
  output kwp_pkg::frame_state_t  st_nxt,
  output kwp_pkg::frame_result_t res
);

  always_comb begin
    logic [2:0] hl;
    logic [7:0] dl;
    logic [8:0] dc;
    logic [7:0] sum;
    logic [2:0] hc_n;
    logic [8:0] dc_n;
    logic       finish;

    hl     = st.hdr_len;
    dl     = st.data_len;
    dc     = st.data_cnt;
    sum    = st.sum;
    hc_n   = st.hdr_cnt;
    dc_n   = st.data_cnt;
    finish = 1'b0;
    res    = '0;
    st_nxt = st;

    if (abort) begin
      // Drop the partial frame
      res.status = kwp_pkg::STS_ABORTED;
      st_nxt     = '0;
    end else if (st.hdr_cnt == 3'd0 && rx_byte[7:6] == kwp_pkg::FMT_MODE_BAD) begin
      res.status  = kwp_pkg::STS_ERROR;
      res.hdr_len = 3'd1;
      st_nxt      = '0;
    end else begin
      if (st.hdr_cnt == 3'd0) begin
        // Decode the format byte
        hl  = 3'd1 + (rx_byte[7] ? 3'd2 : 3'd0) + ((rx_byte[5:0] == 6'd0) ? 3'd1 : 3'd0);
        dl  = {2'b00, rx_byte[5:0]};
        dc  = 9'd0;
        sum = 8'd0;
      end
      dc_n = dc;
      if (st.hdr_cnt != hl) begin
        hc_n = st.hdr_cnt + 3'd1;
        sum  = sum + rx_byte;
        if (dl == 8'd0 && hc_n == hl) begin
          dl = rx_byte;
        end
        res.status = kwp_pkg::STS_NEED;
      end else begin
        dc_n = dc + 9'd1;
        if (dc_n <= {1'b0, dl}) begin
          res.payload_valid = 1'b1;
          res.payload_index = dc[7:0];
          res.payload_byte  = rx_byte;
          sum               = sum + rx_byte;
          res.status        = kwp_pkg::STS_NEED;
        end else begin
          res.status = (sum == rx_byte) ? kwp_pkg::STS_DONE_OK : kwp_pkg::STS_ERROR;
          finish     = 1'b1;
        end
      end
      res.hdr_len  = hl;
      res.data_len = dl;
      if (finish) begin
        st_nxt = '0;
      end else begin
        st_nxt.hdr_cnt  = hc_n;
        st_nxt.hdr_len  = hl;
        st_nxt.data_len = dl;
        st_nxt.data_cnt = dc_n;
        st_nxt.sum      = sum;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/kwp2000_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// KWP2000 frame receiver
// Byte-serial ISO 14230 frame recognizer with payload indexing and checksum.
// ----------------------------------------------------------------------------
// Output: each byte's result is registered and shown in the cycle after its byte's transaction.
// Throughput: one byte per cycle while the result side does not stall; the frame state updates in a single pass
//   between its register and the output register.
// Reset: rst_n low (synchronous) returns the frame state to idle and empties
//   the output register.
`timescale 1ns / 1ps
`default_nettype none

module kwp2000_frame_receiver_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [kwp_pkg::IN_TDATA_W-1:0]      in_tdata,   // [7:0] rx_byte
  input  wire logic                                in_tuser,   // [0] abort
  // Result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [7:0] payload_index, [15:8] payload_byte, [18:16] frame_header_length,
  // [26:19] frame_data_length, [31:27] zero
  output logic [kwp_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic [kwp_pkg::OUT_TUSER_W-1:0]          out_tuser   // [1:0] status, [2] payload_valid
);

  kwp_pkg::frame_state_t  st_r;
  kwp_pkg::frame_state_t  st_nxt;
  kwp_pkg::frame_result_t res;

  logic                               out_valid_r;
  logic [kwp_pkg::OUT_TDATA_W-1:0]    out_tdata_r;
  logic [kwp_pkg::OUT_TUSER_W-1:0]    out_tuser_r;
  logic                               in_accept;

  // Take a new byte whenever the output register is empty or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  kwp_frame_step u_step (
    .st      (st_r),
    .rx_byte (in_tdata),
    .abort   (in_tuser),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        // Advance the frame state and load the result
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload register: hold while the downstream side stalls
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_tdata_r <= {5'd0, res.data_len, res.hdr_len, res.payload_byte, res.payload_index};
      out_tuser_r <= {res.payload_valid, res.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

@@ hdl/kwp_checker.sv @@
// ----------------------------------------------------------------------------
// KWP2000 frame receiver checker
// Port-level properties of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "kwp2000_frame_receiver_unit_macros.svh"

module kwp_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [kwp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic [kwp_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  logic       pvalid;
  logic [1:0] status;
  logic [7:0] pidx;
  logic [7:0] dlen;

  assign pvalid = out_tuser[2];
  assign status = out_tuser[1:0];
  assign pidx   = out_tdata[kwp_pkg::PIDX_LSB +: 8];
  assign dlen   = out_tdata[kwp_pkg::DLEN_MSB:kwp_pkg::DLEN_LSB];

  // A stalled result holds
  `KWP_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // An empty output register never blocks input
  `KWP_ASSERT_NOW(a_no_idle_stall, clk, rst_n, !out_tvalid, in_tready)

  // Payload bytes only come while the frame still needs more
  `KWP_ASSERT_NOW(a_payload_need, clk, rst_n, out_tvalid && pvalid,
    status == kwp_pkg::STS_NEED && pidx < dlen)

  // Abort reports nothing else
  `KWP_ASSERT_NOW(a_abort_clean, clk, rst_n, out_tvalid && status == kwp_pkg::STS_ABORTED,
    !pvalid && out_tdata == '0)

endmodule

bind kwp2000_frame_receiver_unit kwp_checker u_kwp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

@@ sim/tb_kwp2000_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// KWP2000 frame receiver testbench
// Streams received bytes into the unit: first a short directed table that
// covers aborts, rejected format bytes, zero-length, addressed and bad-checksum
// frames, then random frames with random content mixed with noise and
// truncated frames. A frame tracker predicts each result transaction that the table does not give, and the
// scoreboard checks each one field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_kwp2000_frame_receiver_unit;
  import kwp_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // Format byte fields used to build frames
  localparam logic [7:0] FMT_ADDR_BIT = 8'h80;
  localparam logic [7:0] FMT_LEN_MASK = 8'h3F;
  localparam logic [1:0] MODE_PLAIN   = 2'b00;
  localparam logic [1:0] MODE_ADDR_A  = 2'b10;
  localparam logic [1:0] MODE_ADDR_B  = 2'b11;

  typedef struct packed {
    logic [7:0]    rx;
    logic          abort;
    logic          typed;   // 1: use want below, 0: take the tracker's result
    frame_result_t want;
  } stim_row_t;

  localparam frame_result_t FROM_TRACKER = '0;

  // Directed table: extremes, bad modes, special frame shapes
  localparam stim_row_t DIRECTED [24] = '{
    // abort straight out of reset, byte ignored
    '{8'hFF, 1'b1, 1'b1, '{STS_ABORTED, 1'b0, 8'h00, 8'h00, 3'd0, 8'h00}},
    // mode 01 format bytes are rejected
    '{8'h40, 1'b0, 1'b1, '{STS_ERROR, 1'b0, 8'h00, 8'h00, 3'd1, 8'h00}},
    '{8'h7F, 1'b0, 1'b1, '{STS_ERROR, 1'b0, 8'h00, 8'h00, 3'd1, 8'h00}},
    // length byte of zero: no data, checksum follows
    '{8'h00, 1'b0, 1'b0, FROM_TRACKER},
    '{8'h00, 1'b0, 1'b0, FROM_TRACKER},
    '{8'h00, 1'b0, 1'b1, '{STS_DONE_OK, 1'b0, 8'h00, 8'h00, 3'd2, 8'h00}},
    // addressed frame, one data byte, good checksum
    '{8'h81, 1'b0, 1'b0, FROM_TRACKER},
    '{8'hF1, 1'b0, 1'b0, FROM_TRACKER},
    '{8'h10, 1'b0, 1'b0, FROM_TRACKER},
    '{8'hFF, 1'b0, 1'b0, FROM_TRACKER},
    '{8'h81, 1'b0, 1'b1, '{STS_DONE_OK, 1'b0, 8'h00, 8'h00, 3'd3, 8'h01}},
    // longest header, bad checksum
    '{8'hC0, 1'b0, 1'b0, FROM_TRACKER},
    '{8'h00, 1'b0, 1'b0, FROM_TRACKER},
    '{8'hFF, 1'b0, 1'b0, FROM_TRACKER},
    '{8'h01, 1'b0, 1'b0, FROM_TRACKER},
    '{8'h00, 1'b0, 1'b0, FROM_TRACKER},
    '{8'h55, 1'b0, 1'b1, '{STS_ERROR, 1'b0, 8'h00, 8'h00, 3'd4, 8'h01}},
    // abort in the middle of a frame
    '{8'h02, 1'b0, 1'b0, FROM_TRACKER},
    '{8'hAA, 1'b0, 1'b0, FROM_TRACKER},
    '{8'h00, 1'b1, 1'b1, '{STS_ABORTED, 1'b0, 8'h00, 8'h00, 3'd0, 8'h00}},
    // short header frame, two data bytes
    '{8'h02, 1'b0, 1'b0, FROM_TRACKER},
    '{8'h12, 1'b0, 1'b0, FROM_TRACKER},
    '{8'h34, 1'b0, 1'b0, FROM_TRACKER},
    '{8'h48, 1'b0, 1'b0, FROM_TRACKER}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // [7:0] rx_byte
  logic                   in_tuser;    // [0] abort
  logic                   out_tvalid;
  logic                   out_tready;
  // [7:0] payload_index, [15:8] payload_byte, [18:16] frame_header_length,
  // [26:19] frame_data_length, [31:27] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;   // [1:0] status, [2] payload_valid

  frame_state_t  rx_frame;             // tracker's copy of the frame state
  frame_result_t expected_results[$];
  int unsigned   mismatches;
  int unsigned   bytes_sent;
  int unsigned   calm_left;
  int unsigned   cycle_count;

  kwp2000_frame_receiver_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Frame tracker: advance the frame state by one byte, return the result.
  function automatic frame_result_t track_frame(input logic [7:0] rx, input logic abort);
    frame_result_t res;
    logic          finish;
    res    = '0;
    finish = 1'b0;
    if (abort) begin
      rx_frame   = '0;
      res.status = STS_ABORTED;
      return res;
    end
    // Idle: this byte is the format byte
    if (rx_frame.hdr_cnt == 3'd0) begin
      rx_frame.hdr_len  = 3'd1;
      rx_frame.data_len = 8'h00;
      rx_frame.data_cnt = 9'd0;
      rx_frame.sum      = 8'h00;
      if (rx[7:6] == FMT_MODE_BAD) begin
        rx_frame    = '0;
        res.status  = STS_ERROR;
        res.hdr_len = 3'd1;
        return res;
      end
      if ((rx & FMT_ADDR_BIT) != 8'h00) rx_frame.hdr_len = rx_frame.hdr_len + 3'd2;
      if ((rx & FMT_LEN_MASK) == 8'h00) rx_frame.hdr_len = rx_frame.hdr_len + 3'd1;
      else rx_frame.data_len = rx & FMT_LEN_MASK;
    end
    if (rx_frame.hdr_cnt != rx_frame.hdr_len) begin
      rx_frame.hdr_cnt = rx_frame.hdr_cnt + 3'd1;
      rx_frame.sum     = rx_frame.sum + rx;
      // last header byte carries the length when the format byte did not
      if (rx_frame.data_len == 8'h00 && rx_frame.hdr_cnt == rx_frame.hdr_len)
        rx_frame.data_len = rx;
      res.status = STS_NEED;
    end else begin
      rx_frame.data_cnt = rx_frame.data_cnt + 9'd1;
      if (rx_frame.data_cnt <= {1'b0, rx_frame.data_len}) begin
        res.payload_valid = 1'b1;
        res.payload_index = rx_frame.data_cnt[7:0] - 8'd1;
        res.payload_byte  = rx;
        rx_frame.sum      = rx_frame.sum + rx;
        res.status        = STS_NEED;
      end else begin
        res.status = (rx_frame.sum == rx) ? STS_DONE_OK : STS_ERROR;
        finish     = 1'b1;
      end
    end
    res.hdr_len  = rx_frame.hdr_len;
    res.data_len = rx_frame.data_len;
    if (finish) rx_frame = '0;
    return res;
  endfunction

  // Pick the idle gap before the next byte: mostly none or short, a few long,
  // with calm stretches where bytes go back to back.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left != 0) begin
      calm_left = calm_left - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      calm_left = $urandom_range(50, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Drive one byte transaction, wait for it to be taken, record the result.
  task automatic push_byte(input logic [7:0] rx, input logic abort, input logic typed,
                           input frame_result_t want);
    int unsigned   gap;
    frame_result_t got;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    in_tuser  <= abort;
    do @(posedge clk); while (!in_tready);
    got = track_frame(rx, abort);
    expected_results.push_back(typed ? want : got);
    bytes_sent = bytes_sent + 1;
  endtask

  // Build one random frame, or some noise, and send it.
  task automatic send_random_frame();
    logic [7:0]  bytes_q[$];
    logic [7:0]  fmt;
    logic [7:0]  dlen;
    logic [7:0]  csum;
    logic [7:0]  b;
    logic [1:0]  mode;
    logic        use_len_byte;
    int unsigned kind;
    int unsigned r;
    int unsigned cut;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      // well-formed frame with random content
      r    = $urandom_range(0, 2);
      mode = (r == 0) ? MODE_PLAIN : (r == 1) ? MODE_ADDR_A : MODE_ADDR_B;
      r    = $urandom_range(0, 99);
      if (r < 85) dlen = 8'($urandom_range(0, 8));
      else if (r < 97) dlen = 8'($urandom_range(9, 63));
      else dlen = 8'($urandom_range(64, 255));
      use_len_byte = ($urandom_range(0, 3) == 0) || dlen == 8'h00 || dlen > FMT_LEN_MASK;
      fmt = {mode, use_len_byte ? 6'd0 : dlen[5:0]};
      bytes_q.push_back(fmt);
      if ((fmt & FMT_ADDR_BIT) != 8'h00) begin
        bytes_q.push_back(8'($urandom_range(0, 255)));
        bytes_q.push_back(8'($urandom_range(0, 255)));
      end
      if (use_len_byte) bytes_q.push_back(dlen);
      for (int unsigned i = 0; i < dlen; i++) begin
        r = $urandom_range(0, 99);
        b = (r < 8) ? 8'h00 : (r < 16) ? 8'hFF : 8'($urandom_range(0, 255));
        bytes_q.push_back(b);
      end
      csum = 8'h00;
      foreach (bytes_q[i]) csum = csum + bytes_q[i];
      if ($urandom_range(0, 9) == 0) csum = csum ^ 8'($urandom_range(1, 255));
      bytes_q.push_back(csum);
      // truncate now and then with an abort, as on a line error
      if ($urandom_range(0, 19) == 0) begin
        cut = $urandom_range(0, bytes_q.size() - 1);
        while (bytes_q.size() > cut) void'(bytes_q.pop_back());
        foreach (bytes_q[i]) push_byte(bytes_q[i], 1'b0, 1'b0, FROM_TRACKER);
        push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, FROM_TRACKER);
      end else begin
        foreach (bytes_q[i]) push_byte(bytes_q[i], 1'b0, 1'b0, FROM_TRACKER);
      end
    end else if (kind < 90) begin
      // noise, mostly closed by an abort to get back in step
      r = $urandom_range(1, 6);
      repeat (r) push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 4) == 0), 1'b0,
                           FROM_TRACKER);
      if ($urandom_range(0, 3) != 0)
        push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, FROM_TRACKER);
    end else if (kind < 96) begin
      // rejected mode while idle, or whatever the state makes of it
      push_byte({FMT_MODE_BAD, 6'($urandom_range(0, 63))}, 1'b0, 1'b0, FROM_TRACKER);
    end else begin
      push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, FROM_TRACKER);
    end
  endtask

  // Compare one result transaction against the oldest expectation.
  task automatic check_result(input frame_result_t want);
    if (out_tuser[1:0] != want.status) begin
      $error("status: expected %0d, actual %0d", want.status, out_tuser[1:0]);
      mismatches++;
    end
    if (out_tuser[2] != want.payload_valid) begin
      $error("payload_valid: expected %0d, actual %0d", want.payload_valid, out_tuser[2]);
      mismatches++;
    end
    if (out_tdata[PIDX_LSB +: 8] != want.payload_index) begin
      $error("payload_index: expected %0d, actual %0d", want.payload_index,
             out_tdata[PIDX_LSB +: 8]);
      mismatches++;
    end
    if (out_tdata[PBYTE_LSB +: 8] != want.payload_byte) begin
      $error("payload_byte: expected %0h, actual %0h", want.payload_byte,
             out_tdata[PBYTE_LSB +: 8]);
      mismatches++;
    end
    if (out_tdata[HLEN_LSB +: 3] != want.hdr_len) begin
      $error("frame_header_length: expected %0d, actual %0d", want.hdr_len,
             out_tdata[HLEN_LSB +: 3]);
      mismatches++;
    end
    if (out_tdata[DLEN_MSB:DLEN_LSB] != want.data_len) begin
      $error("frame_data_length: expected %0d, actual %0d", want.data_len,
             out_tdata[DLEN_MSB:DLEN_LSB]);
      mismatches++;
    end
    if (out_tdata[OUT_TDATA_W-1:DLEN_MSB+1] != '0) begin
      $error("tdata padding: expected 0, actual %0h", out_tdata[OUT_TDATA_W-1:DLEN_MSB+1]);
      mismatches++;
    end
  endtask

  // Scoreboard: every result transaction must match the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected: tuser %0h tdata %0h",
               out_tuser, out_tdata);
        mismatches++;
      end else begin
        check_result(expected_results.pop_front());
      end
    end
  end

  // Result side backpressure: ready bursts, short stalls, a few long ones.
  initial begin
    int unsigned r;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      r = $urandom_range(0, 99);
      out_tready <= 1'b1;
      if (r < 3) repeat ($urandom_range(100, 300)) @(posedge clk);
      else repeat ($urandom_range(1, 12)) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        // no stall this round
      end else begin
        out_tready <= 1'b0;
        if (r < 92) repeat ($urandom_range(1, 3)) @(posedge clk);
        else repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Stimulus: reset, directed table, random frames, then drain and report.
  initial begin
    mismatches = 0;
    bytes_sent = 0;
    calm_left  = 0;
    rx_frame   = '0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i])
      push_byte(DIRECTED[i].rx, DIRECTED[i].abort, DIRECTED[i].typed, DIRECTED[i].want);

    bytes_sent = 0;
    while (bytes_sent < RANDOM_ITEMS) send_random_frame();
    in_tvalid <= 1'b0;

    // Hold until every expected result has arrived, then let stragglers show.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
